>>> design/tmt_pkg.sv
// Package with shared constants and types for the transaction match table.
package tmt_pkg;
    localparam int TableDepth = 16;
    localparam int TagBits = 8;
    localparam int IdxBits = $clog2(TableDepth);
    localparam int CntBits = $clog2(TableDepth + 1);

    localparam logic [1:0] TypeReq  = 2'd0;
    localparam logic [1:0] TypeResp = 2'd1;
    localparam logic [1:0] TypeTick = 2'd2;

    localparam logic [2:0] OutStored    = 3'd0;
    localparam logic [2:0] OutInvalid   = 3'd1;
    localparam logic [2:0] OutFull      = 3'd2;
    localparam logic [2:0] OutUnmatched = 3'd3;
    localparam logic [2:0] OutMatched   = 3'd4;
    localparam logic [2:0] OutRejected  = 3'd5;
    localparam logic [2:0] OutAged      = 3'd6;

    localparam logic [47:0] MaxAgeReset = 48'd1000000;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_status;

    function automatic logic request_ok(input logic [3:0] op, input logic h1,
                                        input logic h2, input logic n1,
                                        input logic n2);
        logic ok;
        ok = 1'b0;
        if (op <= 4'd3) ok = h1;
        else if (op <= 4'd8) ok = h1 & n1;
        else if (op == 4'd9) ok = h1 & h2 & n1 & n2;
        else if (op == 4'd10) ok = h1 & h2 & n1;
        else if (op == 4'd11) ok = h1 & n1 & n2;
        return ok;
    endfunction
endpackage

>>> design/tmt_ctrl.sv
// Controller state machine that sequences the entry scan for each item.
module tmt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output tmt_pkg::t_cmd    o_cmd,
    input  tmt_pkg::t_status i_status
);
    import tmt_pkg::*;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StScan = 2'd1;
    localparam logic [1:0] StDone = 2'd2;
    localparam logic [1:0] StOut  = 2'd3;

    logic [1:0] r_state, n_state;

    assign o_ready = (r_state == StIdle);
    assign o_valid = (r_state == StOut);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            StIdle: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = StScan;
                end
            end
            StScan: begin
                o_cmd.scan = 1'b1;
                if (i_status.last) n_state = StDone;
            end
            StDone: begin
                o_cmd.finish = 1'b1;
                n_state = StOut;
            end
            StOut: begin
                if (i_ready) n_state = StIdle;
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= StIdle;
        else r_state <= n_state;
    end

    a_out_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StDone) |=> o_valid) else $error("no result after scan");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_ready) else $error("accepted twice");
endmodule

>>> design/tmt_dp.sv
// Datapath with the entry table, the scan pointer and the result register.
module tmt_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tmt_pkg::t_cmd    i_cmd,
    output tmt_pkg::t_status o_status,
    input  logic [47:0]      i_max_age,
    input  logic [1:0]       i_req_type,
    input  logic [31:0]      i_xid,
    input  logic [3:0]       i_operation,
    input  logic             i_has_handle,
    input  logic             i_has_handle2,
    input  logic             i_has_name,
    input  logic             i_has_name2,
    input  logic             i_status_ok,
    input  logic [47:0]      i_timestamp,
    input  logic [7:0]       i_frame_tag,
    output logic [2:0]       o_outcome,
    output logic [7:0]       o_matched_tag,
    output logic [4:0]       o_evicted_count
);
    import tmt_pkg::*;

    logic [TableDepth-1:0] r_valid;
    logic [31:0]           r_exid [TableDepth];
    logic [3:0]            r_eop  [TableDepth];
    logic [47:0]           r_etime[TableDepth];
    logic [TagBits-1:0]    r_etag [TableDepth];

    logic [1:0]  r_type;
    logic [31:0] r_xid;
    logic [3:0]  r_op;
    logic        r_req_ok, r_ok, r_cut_ok;
    logic [47:0] r_ts, r_cutoff;
    logic [7:0]  r_tag;
    logic [IdxBits-1:0] r_ptr;
    logic        r_hit, r_free;
    logic [IdxBits-1:0] r_hit_idx, r_free_idx;
    logic [CntBits-1:0] r_count;
    logic [2:0]  r_outcome;
    logic [7:0]  r_mtag;
    logic [4:0]  r_evicted;

    logic        cur_valid, cur_match, cur_old;
    logic [47:0] dt;
    logic        late;

    assign cur_valid = r_valid[r_ptr];
    assign cur_match = cur_valid && (r_exid[r_ptr] == r_xid);
    assign cur_old   = cur_valid && r_cut_ok && (r_etime[r_ptr] < r_cutoff);
    assign dt   = r_ts - r_etime[r_hit_idx];
    assign late = (r_ts >= r_etime[r_hit_idx]) && (dt > i_max_age);

    assign o_status.last = (r_ptr == IdxBits'(TableDepth - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_req_type;
            r_xid <= i_xid;
            r_op <= i_operation;
            r_req_ok <= request_ok(i_operation, i_has_handle, i_has_handle2,
                                   i_has_name, i_has_name2);
            r_ok <= i_status_ok;
            r_ts <= i_timestamp;
            r_cutoff <= i_timestamp - i_max_age;
            r_cut_ok <= (i_timestamp >= i_max_age);
            r_tag <= i_frame_tag;
            r_ptr <= '0;
            r_hit <= 1'b0;
            r_free <= 1'b0;
            r_count <= '0;
        end
        if (i_cmd.scan) begin
            r_ptr <= r_ptr + 1'b1;
            if (cur_match && !r_hit) begin
                r_hit <= 1'b1;
                r_hit_idx <= r_ptr;
            end
            if (!cur_valid && !r_free) begin
                r_free <= 1'b1;
                r_free_idx <= r_ptr;
            end
            if (r_type == TypeTick && cur_old) r_count <= r_count + 1'b1;
        end
        if (i_cmd.finish) begin
            r_mtag <= '0;
            r_evicted <= '0;
            unique case (r_type)
                TypeReq: begin
                    if (!r_req_ok) r_outcome <= OutInvalid;
                    else if (!r_hit && !r_free) r_outcome <= OutFull;
                    else r_outcome <= OutStored;
                end
                TypeResp: begin
                    if (!r_hit) r_outcome <= OutUnmatched;
                    else begin
                        r_mtag <= 8'(r_etag[r_hit_idx]);
                        r_outcome <= (!r_ok || r_op != r_eop[r_hit_idx] || late)
                                     ? OutRejected : OutMatched;
                    end
                end
                TypeTick: begin
                    r_outcome <= OutAged;
                    r_evicted <= 5'(r_count);
                end
                default: r_outcome <= OutInvalid;
            endcase
            if (r_type == TypeReq && r_req_ok && (r_hit || r_free)) begin
                r_exid[r_hit ? r_hit_idx : r_free_idx] <= r_xid;
                r_eop[r_hit ? r_hit_idx : r_free_idx] <= r_op;
                r_etime[r_hit ? r_hit_idx : r_free_idx] <= r_ts;
                r_etag[r_hit ? r_hit_idx : r_free_idx] <= r_tag[TagBits-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.scan && r_type == TypeTick && cur_old) r_valid[r_ptr] <= 1'b0;
            if (i_cmd.finish) begin
                if (r_type == TypeReq && r_req_ok && (r_hit || r_free))
                    r_valid[r_hit ? r_hit_idx : r_free_idx] <= 1'b1;
                if (r_type == TypeResp && r_hit) r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    assign o_outcome = r_outcome;
    assign o_matched_tag = r_mtag;
    assign o_evicted_count = r_evicted;

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_type == TypeResp && r_hit) |-> r_valid[r_hit_idx])
        else $error("hit entry not valid");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> r_count <= CntBits'(TableDepth)) else $error("count overflow");
    a_resp_removes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_type == TypeResp && r_hit) |=>
        !r_valid[$past(r_hit_idx)]) else $error("entry not removed");
endmodule

>>> design/transaction_match_table.sv
// Top level of the transaction match table.
// An item is accepted only while the block is idle. The accepting edge loads the
// item, the scan then steps through every entry at one entry per cycle, and the
// done state forms the result, which is held until taken. The next item can be
// accepted in the cycle after the result has been taken, so a new item is not
// taken before the last one is through.
module transaction_match_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_xid,
    input  logic [3:0]  i_operation,
    input  logic        i_has_handle,
    input  logic        i_has_handle2,
    input  logic        i_has_name,
    input  logic        i_has_name2,
    input  logic        i_status_ok,
    input  logic [47:0] i_timestamp,
    input  logic [7:0]  i_frame_tag,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_outcome,
    output logic [7:0]  o_matched_tag,
    output logic [4:0]  o_evicted_count
);
    import tmt_pkg::*;

    logic [47:0] r_max_age;
    t_cmd    cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_age <= MaxAgeReset;
        else if (i_cfg_we) r_max_age <= i_cfg_data;
    end

    tmt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .o_cmd(cmd), .i_status(status)
    );

    tmt_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_max_age(r_max_age), .i_req_type(i_req_type), .i_xid(i_xid),
        .i_operation(i_operation), .i_has_handle(i_has_handle),
        .i_has_handle2(i_has_handle2), .i_has_name(i_has_name),
        .i_has_name2(i_has_name2), .i_status_ok(i_status_ok),
        .i_timestamp(i_timestamp), .i_frame_tag(i_frame_tag),
        .o_outcome(o_outcome), .o_matched_tag(o_matched_tag),
        .o_evicted_count(o_evicted_count)
    );
endmodule
